FILE: rtl/core/twsrm_pkg.sv
package twsrm_pkg;

  localparam int unsigned CmdW   = 8;
  localparam int unsigned ValueW = 16;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CountW = 4;

  // Opcodes carried by each tick
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_TEMP  = 2'd1;
  localparam logic [1:0] OP_HUMID = 2'd2;

  // Sensor commands
  localparam logic [CmdW-1:0] CMD_TEMPERATURE = 8'b0000_0011;
  localparam logic [CmdW-1:0] CMD_HUMIDITY    = 8'b0000_0101;

  localparam logic [LimitW-1:0] WAIT_LIMIT_RESET = 16'd1000;
  localparam logic [LimitW-1:0] WAIT_COUNT_MAX   = 16'hFFFF;

  // Bit counts at which the read sequence turns
  localparam logic [CountW-1:0] BITS_PER_BYTE = 4'd8;
  localparam logic [CountW-1:0] BITS_WRAPPED  = 4'd0;

  // One result per tick
  typedef struct packed {
    logic              clock_out;
    logic              data_out;
    logic              data_drive;
    logic              busy_res;
    logic              done_res;
    logic [ValueW-1:0] raw_value;
    logic              timed_out;
  } result_t;

endpackage

FILE: rtl/core/twsrm_seq.sv
module twsrm_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [15:0]              cfg_wdata_i,
  input  logic                     accept_i,
  input  logic [1:0]               opcode_i,
  input  logic                     data_in_i,
  output twsrm_pkg::result_t       res_o
);
  import twsrm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_S0   = 5'd1,
    PH_S1   = 5'd2,
    PH_S2   = 5'd3,
    PH_S3   = 5'd4,
    PH_S4   = 5'd5,
    PH_S5   = 5'd6,
    PH_S6   = 5'd7,
    PH_CSET = 5'd8,
    PH_CHI  = 5'd9,
    PH_ALO  = 5'd10,
    PH_AHI  = 5'd11,
    PH_WAIT = 5'd12,
    PH_RHI  = 5'd13,
    PH_RLO  = 5'd14,
    PH_MSET = 5'd15,
    PH_MHI  = 5'd16,
    PH_MLO  = 5'd17,
    PH_ESET = 5'd18,
    PH_EHI  = 5'd19
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   bits_q, bits_d;
  logic [CmdW-1:0]     cmd_q, cmd_d;
  logic [ValueW-1:0]   shift_q, shift_d;
  logic [LimitW-1:0]   wait_q, wait_d;
  logic [LimitW-1:0]   wait_inc;
  logic [LimitW-1:0]   limit_q;
  logic                tout_q, tout_d;
  logic [ValueW-1:0]   last_q, last_d;
  logic                done;
  logic                clk_l, dat_l, drv_l;

  assign wait_inc = (wait_q != WAIT_COUNT_MAX) ? wait_q + 16'd1 : wait_q;

  always_comb begin
    phase_d = phase_q;
    bits_d  = bits_q;
    cmd_d   = cmd_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    tout_d  = tout_q;
    last_d  = last_q;
    done    = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (opcode_i == OP_TEMP || opcode_i == OP_HUMID) begin
          cmd_d   = (opcode_i == OP_TEMP) ? CMD_TEMPERATURE : CMD_HUMIDITY;
          bits_d  = '0;
          wait_d  = '0;
          tout_d  = 1'b0;
          phase_d = PH_S0;
        end
      end
      PH_S0, PH_S1, PH_S2, PH_S3, PH_S4, PH_S5, PH_S6, PH_CSET,
      PH_ALO, PH_MSET, PH_MHI, PH_ESET: begin
        phase_d = phase_e'(phase_q + 5'd1);
      end
      PH_CHI: begin
        cmd_d   = {cmd_q[CmdW-2:0], 1'b0};
        bits_d  = bits_q + 4'd1;
        phase_d = (bits_d == BITS_PER_BYTE) ? PH_ALO : PH_CSET;
      end
      PH_AHI: phase_d = PH_WAIT;
      PH_WAIT: begin
        if (!data_in_i) begin
          bits_d  = '0;
          phase_d = PH_RHI;
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= limit_q) begin
            tout_d  = 1'b1;
            bits_d  = '0;
            phase_d = PH_RHI;
          end
        end
      end
      PH_RHI: begin
        shift_d = {shift_q[ValueW-2:0], data_in_i};
        bits_d  = bits_q + 4'd1;
        phase_d = PH_RLO;
      end
      PH_RLO: begin
        if (bits_q == BITS_PER_BYTE) begin
          phase_d = PH_MSET;
        end else if (bits_q == BITS_WRAPPED) begin
          phase_d = PH_ESET;
        end else begin
          phase_d = PH_RHI;
        end
      end
      PH_MLO: phase_d = PH_RHI;
      PH_EHI: begin
        last_d  = shift_q;
        done    = 1'b1;
        phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Line levels for the phase just entered
  always_comb begin
    clk_l = 1'b0;
    dat_l = 1'b0;
    drv_l = 1'b0;
    case (phase_d)
      PH_S0:   begin dat_l = 1'b1; drv_l = 1'b1; end
      PH_S1:   begin clk_l = 1'b1; dat_l = 1'b1; drv_l = 1'b1; end
      PH_S2:   begin clk_l = 1'b1; drv_l = 1'b1; end
      PH_S3:   drv_l = 1'b1;
      PH_S4:   begin clk_l = 1'b1; drv_l = 1'b1; end
      PH_S5:   begin clk_l = 1'b1; dat_l = 1'b1; drv_l = 1'b1; end
      PH_S6:   begin dat_l = 1'b1; drv_l = 1'b1; end
      PH_CSET: begin dat_l = cmd_d[CmdW-1]; drv_l = 1'b1; end
      PH_CHI:  begin clk_l = 1'b1; dat_l = cmd_d[CmdW-1]; drv_l = 1'b1; end
      PH_AHI:  clk_l = 1'b1;
      PH_RHI:  clk_l = 1'b1;
      PH_MSET: drv_l = 1'b1;
      PH_MHI:  begin clk_l = 1'b1; drv_l = 1'b1; end
      PH_MLO:  drv_l = 1'b1;
      PH_ESET: begin dat_l = 1'b1; drv_l = 1'b1; end
      PH_EHI:  begin clk_l = 1'b1; dat_l = 1'b1; drv_l = 1'b1; end
      default: begin
        clk_l = 1'b0;
        dat_l = 1'b0;
        drv_l = 1'b0;
      end
    endcase
    // hold data high with clock low on the finishing tick
    if (done) begin
      clk_l = 1'b0;
      dat_l = 1'b1;
      drv_l = 1'b1;
    end
  end

  always_comb begin
    res_o.clock_out  = clk_l;
    res_o.data_out   = dat_l;
    res_o.data_drive = drv_l;
    res_o.busy_res   = (phase_d != PH_IDLE);
    res_o.done_res   = done;
    res_o.raw_value  = last_d;
    res_o.timed_out  = tout_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bits_q  <= '0;
      cmd_q   <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      tout_q  <= 1'b0;
      last_q  <= '0;
      limit_q <= WAIT_LIMIT_RESET;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q <= phase_d;
        bits_q  <= bits_d;
        cmd_q   <= cmd_d;
        shift_q <= shift_d;
        wait_q  <= wait_d;
        tout_q  <= tout_d;
        last_q  <= last_d;
      end
    end
  end

endmodule

FILE: rtl/core/twsrm_out.sv
module twsrm_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               accept_o,
  input  twsrm_pkg::result_t res_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output twsrm_pkg::result_t res_o
);
  import twsrm_pkg::*;

  logic    valid_q;
  result_t res_q;

  // take a new tick when the register is empty or drains this cycle
  assign in_stall_o  = valid_q && out_stall_i;
  assign accept_o    = in_valid_i && !in_stall_o;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: rtl/core/two_wire_sensor_read_master_unit.sv
// Bit-level master for a two-wire humidity/temperature sensor. Every input
// transaction is one bit-clock phase tick carrying an opcode and the sampled
// data line; every tick yields exactly one result transaction with the clock
// and data levels to drive next, busy/done status, the last raw 16-bit reading
// and the timeout flag. Opcode 1 starts a temperature read and 2 a humidity
// read; both are ignored while busy. A read sends the start pattern and the
// command MSB first, clocks the sensor ack, then polls for data low up to
// wait_limit ticks (written through cfg_we_i/cfg_wdata_i by the user only while
// idle, not enforced by the block; reset value 1000) before reading two bytes
// with a master ack and a closing clock with data high. Rate: one tick per
// clock cycle unless the receiver stalls; the sequencer's phase register
// advances once per tick, and a single result register parts the two channels.
module two_wire_sensor_read_master_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic        data_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        clock_out_o,
  output logic        data_out_o,
  output logic        data_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [15:0] raw_value_o,
  output logic        timed_out_o
);
  import twsrm_pkg::*;

  logic    accept;
  result_t res_next;
  result_t res_reg;

  // Sequencer: advance one phase per accepted tick
  twsrm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .data_in_i  (data_in_i),
    .res_o      (res_next)
  );

  // Result register: hold the result while the far side stalls
  twsrm_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .accept_o   (accept),
    .res_i      (res_next),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_reg)
  );

  assign clock_out_o  = res_reg.clock_out;
  assign data_out_o   = res_reg.data_out;
  assign data_drive_o = res_reg.data_drive;
  assign busy_res_o   = res_reg.busy_res;
  assign done_res_o   = res_reg.done_res;
  assign raw_value_o  = res_reg.raw_value;
  assign timed_out_o  = res_reg.timed_out;

endmodule

FILE: tb/sensor_read_checker.sv
`timescale 1ns / 100ps

module sensor_read_checker
  import twsrm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        opcode_i,
  input  logic              data_in_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  result_t           seen_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  typedef enum logic [4:0] {
    P_IDLE,
    P_START0, P_START1, P_START2, P_START3, P_START4, P_START5, P_START6,
    P_CMD_SET, P_CMD_HIGH,
    P_ACK_LOW, P_ACK_HIGH,
    P_POLL,
    P_READ_HIGH, P_READ_LOW,
    P_MACK_SET, P_MACK_HIGH, P_MACK_LOW,
    P_END_SET, P_END_HIGH
  } seq_phase_e;

  seq_phase_e        ph;
  logic [CountW-1:0] bits;
  logic [CmdW-1:0]   cmd_sr;
  logic [ValueW-1:0] rd_sr;
  logic [LimitW-1:0] polls;
  logic              tmo;
  logic [ValueW-1:0] last_raw;
  logic [LimitW-1:0] limit;

  result_t     expected_ticks[$];
  result_t     want;
  int unsigned mismatches;

  // Line levels held after a tick in a given phase: {drive, data, clock}.
  function automatic logic [2:0] line_levels(seq_phase_e p);
    logic cb;
    cb = cmd_sr[CmdW-1];
    case (p)
      P_START0, P_START6, P_END_SET: return 3'b110;
      P_START1, P_START5, P_END_HIGH: return 3'b111;
      P_START2, P_START4, P_MACK_HIGH: return 3'b101;
      P_START3, P_MACK_SET, P_MACK_LOW: return 3'b100;
      P_CMD_SET: return {1'b1, cb, 1'b0};
      P_CMD_HIGH: return {1'b1, cb, 1'b1};
      P_ACK_HIGH, P_READ_HIGH: return 3'b001;
      default: return 3'b000;
    endcase
  endfunction

  // Advance the sequencer by one tick and return the levels and status it reports.
  function automatic result_t predict_tick(logic [1:0] op, logic din);
    result_t    res;
    logic       done;
    logic [2:0] lv;
    done = 1'b0;
    case (ph)
      P_IDLE: begin
        if (op == OP_TEMP || op == OP_HUMID) begin
          cmd_sr = (op == OP_TEMP) ? CMD_TEMPERATURE : CMD_HUMIDITY;
          bits   = '0;
          polls  = '0;
          tmo    = 1'b0;
          ph     = P_START0;
        end
      end
      P_START0, P_START1, P_START2, P_START3, P_START4, P_START5, P_START6,
      P_CMD_SET, P_ACK_LOW, P_MACK_SET, P_MACK_HIGH, P_END_SET: begin
        ph = seq_phase_e'(ph + 5'd1);
      end
      P_CMD_HIGH: begin
        cmd_sr = cmd_sr << 1;
        bits   = bits + 1'b1;
        ph     = (bits == BITS_PER_BYTE) ? P_ACK_LOW : P_CMD_SET;
      end
      P_ACK_HIGH: ph = P_POLL;
      P_POLL: begin
        if (!din) begin
          bits = '0;
          ph   = P_READ_HIGH;
        end else begin
          if (polls != WAIT_COUNT_MAX) polls = polls + 1'b1;
          if (polls >= limit) begin
            tmo  = 1'b1;
            bits = '0;
            ph   = P_READ_HIGH;
          end
        end
      end
      P_READ_HIGH: begin
        rd_sr = {rd_sr[ValueW-2:0], din};
        bits  = bits + 1'b1;
        ph    = P_READ_LOW;
      end
      P_READ_LOW: begin
        if (bits == BITS_PER_BYTE) ph = P_MACK_SET;
        else if (bits == BITS_WRAPPED) ph = P_END_SET;
        else ph = P_READ_HIGH;
      end
      P_MACK_LOW: ph = P_READ_HIGH;
      P_END_HIGH: begin
        last_raw = rd_sr;
        done     = 1'b1;
        ph       = P_IDLE;
      end
      default: ph = P_IDLE;
    endcase
    lv = done ? 3'b110 : line_levels(ph);
    res.clock_out  = lv[0];
    res.data_out   = lv[1];
    res.data_drive = lv[2];
    res.busy_res   = (ph != P_IDLE);
    res.done_res   = done;
    res.raw_value  = last_raw;
    res.timed_out  = tmo;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [ValueW-1:0] exp_v,
                             input logic [ValueW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph       = P_IDLE;
      bits     = '0;
      cmd_sr   = '0;
      rd_sr    = '0;
      polls    = '0;
      tmo      = 1'b0;
      last_raw = '0;
      limit    = WAIT_LIMIT_RESET;
      expected_ticks.delete();
    end else begin
      // Retire before predicting: a result never leaves in the cycle its tick enters.
      if (out_valid_i && !out_stall_i) begin
        if (expected_ticks.size() == 0) begin
          $error("result transaction with no tick awaiting it");
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("clock_out", want.clock_out, seen_i.clock_out);
          check_field("data_out", want.data_out, seen_i.data_out);
          check_field("data_drive", want.data_drive, seen_i.data_drive);
          check_field("busy_res", want.busy_res, seen_i.busy_res);
          check_field("done_res", want.done_res, seen_i.done_res);
          check_field("raw_value", want.raw_value, seen_i.raw_value);
          check_field("timed_out", want.timed_out, seen_i.timed_out);
        end
      end
      if (in_valid_i && !in_stall_i) expected_ticks.push_back(predict_tick(opcode_i, data_in_i));
      if (cfg_we_i) limit = cfg_wdata_i;
    end
    pending_o    <= expected_ticks.size();
    fail_count_o <= mismatches;
  end

endmodule

FILE: tb/two_wire_sensor_read_master_unit_test.sv
`timescale 1ns / 100ps

module two_wire_sensor_read_master_unit_test;
  import twsrm_pkg::*;

  localparam int unsigned RESET_CYCLES = 7;
  // Far above the slowest legal run: about 500 ticks under the heaviest
  // stalling, plus the drains around each limit write.
  localparam int unsigned CYCLE_LIMIT = 20_000;
  // Opcode outside the defined set; the block must treat it as a plain tick.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Ticks from the one after the start tick up to the first poll of the data
  // line: seven start-pattern phases, eight command bits of two phases each,
  // and the two phases of the sensor acknowledge.
  localparam int unsigned LEAD_IN_TICKS = 25;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_wdata;
  logic              in_valid;
  logic [1:0]        opcode;
  logic              data_in;
  logic              out_stall = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic              clock_out;
  logic              data_out;
  logic              data_drive;
  logic              busy_res;
  logic              done_res;
  logic [ValueW-1:0] raw_value;
  logic              timed_out;
  result_t           dut_res;

  int unsigned       pending;
  int unsigned       fail_count;
  int unsigned       cycle_count;

  // Stimulus-side copy of the wait limit, used only to shape the poll phase.
  logic [LimitW-1:0] limit_now;
  int unsigned       burst_left;
  int unsigned       gap_len;
  int unsigned       stall_left = 0;
  logic [1:0]        stall_mode = 2'd0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  two_wire_sensor_read_master_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .data_in_i    (data_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .clock_out_o  (clock_out),
    .data_out_o   (data_out),
    .data_drive_o (data_drive),
    .busy_res_o   (busy_res),
    .done_res_o   (done_res),
    .raw_value_o  (raw_value),
    .timed_out_o  (timed_out)
  );

  assign dut_res = {clock_out, data_out, data_drive, busy_res, done_res, raw_value, timed_out};

  // The checker watches both channels and the register port on its own and
  // reports back only how many results are still owed and how many failed.
  sensor_read_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .opcode_i     (opcode),
    .data_in_i    (data_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .seen_i       (dut_res),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Receiver back-pressure: switch between free flow, light stalling, heavy
  // stalling and long held runs, each mode kept for a random stretch.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = 2'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
    endcase
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Opcode for a tick while a transaction runs: either a plain tick or any
  // opcode at all, which the block must ignore while busy.
  function automatic logic [1:0] busy_op(input bit noisy);
    return noisy ? 2'($urandom_range(0, 3)) : OP_TICK;
  endfunction

  // Offer one tick and hold it until the block takes it. The sender works in
  // bursts; at the start of each burst drop valid for a random gap.
  task automatic send_tick(input logic [1:0] op, input logic din);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode   <= op;
    data_in  <= din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Ticks in idle that must not start anything.
  task automatic idle_ticks(input int unsigned n);
    repeat (n) send_tick(coin() ? OP_TICK : OP_UNUSED, coin());
  endtask

  // One complete read as the sensor would answer it. The data line stays high
  // for 'highs' polls before going low; if that reaches the wait limit the
  // block gives up polling, so stop holding it high at exactly that point.
  // Read bits go in on the clock-high ticks, MSB first; every other tick
  // carries a random line level the block must not look at. In noisy mode the
  // finishing tick carries a start opcode, which the block must also ignore.
  task automatic read_cycle(input logic [1:0] op, input int unsigned highs,
                            input logic [ValueW-1:0] value, input bit noisy);
    int unsigned eff;
    eff = (limit_now == 0) ? 1 : limit_now;
    send_tick(op, coin());
    repeat (LEAD_IN_TICKS) send_tick(busy_op(noisy), coin());
    if (highs >= eff) begin
      repeat (eff) send_tick(busy_op(noisy), 1'b1);
    end else begin
      repeat (highs) send_tick(busy_op(noisy), 1'b1);
      send_tick(busy_op(noisy), 1'b0);
    end
    for (int i = ValueW - 1; i >= 0; i--) begin
      send_tick(busy_op(noisy), value[i]);
      send_tick(busy_op(noisy), coin());
      // master acknowledge between the two bytes
      if (i == ValueW / 2) repeat (3) send_tick(busy_op(noisy), coin());
    end
    send_tick(busy_op(noisy), coin());
    send_tick(noisy ? OP_HUMID : OP_TICK, coin());
  endtask

  // Let every owed result drain, then write the wait limit with the block idle.
  task automatic set_limit(input logic [LimitW-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now  = v;
    burst_left = 0;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("two_wire_sensor_read_master_unit_test failed");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    opcode     = OP_TICK;
    data_in    = 1'b0;
    limit_now  = WAIT_LIMIT_RESET;
    burst_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle ticks, the unused opcode among them, must leave the block idle.
    send_tick(OP_TICK, 1'b0);
    send_tick(OP_UNUSED, 1'b1);
    send_tick(OP_UNUSED, 1'b0);
    send_tick(OP_TICK, 1'b1);

    // Reset wait limit: immediate answer with all ones, then all zeros after
    // a short wait with ignored opcodes throughout, then a read started the
    // tick after a finish.
    read_cycle(OP_TEMP, 0, 16'hFFFF, 1'b0);
    read_cycle(OP_HUMID, 3, 16'h0000, 1'b1);
    read_cycle(OP_TEMP, 2, 16'hA55A, 1'b1);

    // A zero limit acts as one poll; check it times out on the first high.
    set_limit('0);
    read_cycle(OP_TEMP, 4, 16'($urandom), 1'b0);

    // Largest limit: a normal read after the timeout clears the flag.
    set_limit(WAIT_COUNT_MAX);
    read_cycle(OP_HUMID, 5, 16'($urandom), 1'b1);

    // Random part: mostly small limits so that timeouts and answers mix.
    repeat (2) begin
      set_limit(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12)));
      idle_ticks($urandom_range(0, 3));
      read_cycle(coin() ? OP_TEMP : OP_HUMID,
                 (limit_now <= 20) ? $urandom_range(0, limit_now + 2)
                                   : $urandom_range(0, 12),
                 16'($urandom), coin());
    end
    idle_ticks($urandom_range(2, 6));

    // Drain, then give anything stray time to show up before the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("two_wire_sensor_read_master_unit_test passed");
    end else begin
      $display("two_wire_sensor_read_master_unit_test failed");
    end
    $finish;
  end

endmodule

FILE: two_wire_sensor_read_master_unit.f
rtl/core/twsrm_pkg.sv
rtl/core/twsrm_seq.sv
rtl/core/twsrm_out.sv
rtl/core/two_wire_sensor_read_master_unit.sv
tb/sensor_read_checker.sv
tb/two_wire_sensor_read_master_unit_test.sv
